// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define GCC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define GCC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gcc_pkg.sv =====
// Shared types and constants of the graph connectivity checker.
`default_nettype none

package gcc_pkg;

   localparam int VERTEX_W   = 6;
   localparam int COUNT_W    = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   // register index as seen in paddr[2]
   localparam logic REG_VERTEX_COUNT = 1'b0;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EDGE_A = 6'b000010,
      ST_EDGE_B = 6'b000100,
      ST_PICK   = 6'b001000,
      ST_MERGE  = 6'b010000,
      ST_DONE   = 6'b100000
   } walk_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear_all;
   } mem_ctl_type;

   typedef struct packed {
      logic [COUNT_W-1:0] reached_count;
      logic               connected;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/gcc_csr.sv =====
// Configuration register file: vertex count behind an APB-style port.
`default_nettype none

module gcc_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [gcc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [gcc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [gcc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output logic [gcc_pkg::COUNT_W-1:0]        vertex_count
);
   import gcc_pkg::*;

   logic [COUNT_W-1:0] vertex_count_ff;
   logic [COUNT_W-1:0] vertex_count_in;
   logic               wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_VERTEX_COUNT);

   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (wr_hit) begin
         vertex_count_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_VERTEX_COUNT) begin
         csr_prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, vertex_count_ff};
      end
   end

   assign vertex_count = vertex_count_ff;

endmodule

`default_nettype wire

// ===== rtl/gcc_adj_mem.sv =====
// Adjacency matrix memory, one row per vertex, with per-row valid flags.
`default_nettype none

module gcc_adj_mem #(
   parameter int MAX_VERTICES = 64
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire  gcc_pkg::mem_ctl_type      ctl,
   input  wire  [$clog2(MAX_VERTICES)-1:0] rd_addr,
   input  wire  [$clog2(MAX_VERTICES)-1:0] wr_addr,
   input  wire  [MAX_VERTICES-1:0]         wr_data,
   output logic [MAX_VERTICES-1:0]         rd_row
);
   import gcc_pkg::*;

   logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [MAX_VERTICES-1:0] row_valid_in;
   logic [MAX_VERTICES-1:0] rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // a row never written since the last clear reads as zero
   always_comb begin
      row_valid_in = row_valid_ff;
      if (ctl.clear_all) begin
         row_valid_in = '0;
      end else if (ctl.wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         if (ctl.rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : {MAX_VERTICES{1'b0}};

endmodule

`default_nettype wire

// ===== rtl/gcc_walk.sv =====
// Sequencer: edge loading by read-modify-write and the reachability walk.
`default_nettype none

module gcc_walk #(
   parameter int MAX_VERTICES = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [gcc_pkg::COUNT_W-1:0]      vertex_count,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_kind,
   input  wire  [gcc_pkg::VERTEX_W-1:0]     req_first,
   input  wire  [gcc_pkg::VERTEX_W-1:0]     req_second,
   output gcc_pkg::mem_ctl_type             mem_ctl,
   output logic [$clog2(MAX_VERTICES)-1:0]  mem_rd_addr,
   output logic [$clog2(MAX_VERTICES)-1:0]  mem_wr_addr,
   output logic [MAX_VERTICES-1:0]          mem_wr_data,
   input  wire  [MAX_VERTICES-1:0]          mem_rd_row,
   input  wire                              out_busy,
   output logic                             res_valid,
   output gcc_pkg::result_type              res
);
   import gcc_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   walk_state_type          state_ff, state_in;
   logic [MAX_VERTICES-1:0] reached_ff, reached_in;
   logic [MAX_VERTICES-1:0] expanded_ff, expanded_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           first_ff, first_in;
   logic [AW-1:0]           second_ff, second_in;
   logic                    edge_ok_ff, edge_ok_in;

   logic [CW-1:0]           eff_cnt;
   logic [COUNT_W-1:0]      eff_cnt_wide;
   logic [MAX_VERTICES-1:0] mask;
   logic [MAX_VERTICES-1:0] pending;
   logic [MAX_VERTICES-1:0] lowest;
   logic [AW-1:0]           pick_idx;
   logic                    edge_ok;

   // count of 0 acts as 1, counts above the matrix size saturate
   always_comb begin
      if (vertex_count == '0) begin
         eff_cnt = CW'(1);
      end else if (vertex_count > COUNT_W'(MAX_VERTICES)) begin
         eff_cnt = CW'(MAX_VERTICES);
      end else begin
         eff_cnt = vertex_count[CW-1:0];
      end
   end

   assign eff_cnt_wide = COUNT_W'(eff_cnt);

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         mask[i] = (CW'(i) < eff_cnt);
      end
   end

   assign edge_ok = ({1'b0, req_first} < eff_cnt_wide) &&
                    ({1'b0, req_second} < eff_cnt_wide);

   // lowest reached-but-unexpanded vertex
   assign pending = reached_ff & ~expanded_ff & mask;
   assign lowest  = pending & (~pending + 1'b1);

   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         pick_idx = pick_idx | (lowest[i] ? AW'(i) : {AW{1'b0}});
      end
   end

   always_comb begin
      state_in    = state_ff;
      reached_in  = reached_ff;
      expanded_in = expanded_ff;
      count_in    = count_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      edge_ok_in  = edge_ok_ff;
      req_ready   = 1'b0;
      mem_ctl     = '0;
      mem_rd_addr = '0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      res_valid   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_EVAL) begin
                  reached_in  = MAX_VERTICES'(1);
                  expanded_in = '0;
                  count_in    = '0;
                  state_in    = ST_PICK;
               end else begin
                  first_in      = req_first[AW-1:0];
                  second_in     = req_second[AW-1:0];
                  edge_ok_in    = edge_ok;
                  mem_ctl.rd_en = 1'b1;
                  mem_rd_addr   = req_first[AW-1:0];
                  state_in      = ST_EDGE_A;
               end
            end
         end
         ST_EDGE_A: begin
            // write row of first end, fetch row of second end
            mem_ctl.wr_en = edge_ok_ff;
            mem_wr_addr   = first_ff;
            mem_wr_data   = mem_rd_row | (MAX_VERTICES'(1) << second_ff);
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = second_ff;
            state_in      = ST_EDGE_B;
         end
         ST_EDGE_B: begin
            mem_ctl.wr_en = edge_ok_ff;
            mem_wr_addr   = second_ff;
            mem_wr_data   = mem_rd_row | (MAX_VERTICES'(1) << first_ff);
            state_in      = ST_IDLE;
         end
         ST_PICK: begin
            if (pending == '0) begin
               state_in = ST_DONE;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = pick_idx;
               expanded_in   = expanded_ff | lowest;
               count_in      = count_ff + 1'b1;
               state_in      = ST_MERGE;
            end
         end
         ST_MERGE: begin
            reached_in = reached_ff | (mem_rd_row & mask);
            state_in   = ST_PICK;
         end
         ST_DONE: begin
            if (!out_busy) begin
               res_valid         = 1'b1;
               mem_ctl.clear_all = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // every reached vertex inside the mask gets expanded exactly once
   assign res.connected     = (count_ff == eff_cnt);
   assign res.reached_count = COUNT_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         reached_ff  <= '0;
         expanded_ff <= '0;
         count_ff    <= '0;
         edge_ok_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         reached_ff  <= reached_in;
         expanded_ff <= expanded_in;
         count_ff    <= count_in;
         edge_ok_ff  <= edge_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
   end

endmodule

`default_nettype wire

// ===== rtl/graph_connectivity_check_core.sv =====
// Top level of the undirected graph connectivity checker.
//
// Edge transfers (tuser 0) set both directions of a bit adjacency matrix held
// in a one-row-per-vertex memory; each edge is two read-modify-write passes.
// An evaluate transfer (tuser 1) walks the graph from vertex 0: each step picks
// the lowest reached but unexpanded vertex, reads its row through the single
// registered read port of the matrix memory and ORs it into the reached set.
// It yields one result transfer with the connected flag and the reached count;
// the matrix is then empty again at once through per-row valid flags, so no
// clearing pass is needed. Edges naming a vertex at or above vertex_count (a
// count of 0 acting as 1) are dropped. Write vertex_count only while idle.
`default_nettype none

module graph_connectivity_check_core #(
   parameter int MAX_VERTICES = 64
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [gcc_pkg::REQ_DATA_W-1:0]  req_tdata,   // first_vertex, second_vertex
   input  wire                             req_tuser,   // kind
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [gcc_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // connected, reached_count
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire  [gcc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [gcc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [gcc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import gcc_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   logic [COUNT_W-1:0]      vertex_count;
   mem_ctl_type             mem_ctl;
   logic [AW-1:0]           mem_rd_addr;
   logic [AW-1:0]           mem_wr_addr;
   logic [MAX_VERTICES-1:0] mem_wr_data;
   logic [MAX_VERTICES-1:0] mem_rd_row;
   logic                    res_valid;
   result_type              res;
   logic                    out_busy;

   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_data_ff, rsp_data_in;

   gcc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .vertex_count (vertex_count)
   );

   gcc_adj_mem #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_row  (mem_rd_row)
   );

   gcc_walk #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .vertex_count (vertex_count),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser),
      .req_first    (req_tdata[VERTEX_W-1:0]),
      .req_second   (req_tdata[2*VERTEX_W-1:VERTEX_W]),
      .mem_ctl      (mem_ctl),
      .mem_rd_addr  (mem_rd_addr),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_row   (mem_rd_row),
      .out_busy     (out_busy),
      .res_valid    (res_valid),
      .res          (res)
   );

   // output register: a new result may load while the old one leaves
   assign out_busy = rsp_valid_ff && !rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/gcc_check.sv =====
// Port-level checker for the connectivity checker, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module gcc_check (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tvalid,
   input wire                            req_tready,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [gcc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import gcc_pkg::*;

   // a stalled result holds
   `GCC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // req_tready is low right after every accepted transfer
   `GCC_ASSERT(a_req_busy, clock, reset, req_tvalid && req_tready |=> !req_tready, "input taken on back-to-back cycles")

   // vertex 0 is always reached, never more than the matrix holds
   `GCC_ASSERT(a_count_range, clock, reset, rsp_tvalid |-> (rsp_tdata[7:1] != 7'd0) && (rsp_tdata[7:1] <= 7'd64), "reached count out of range")

   // nothing pending right after reset
   `GCC_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind graph_connectivity_check_core gcc_check u_gcc_check (.*);

`default_nettype wire
